@@ sv/cigm_pkg.sv @@
// ----------------------------------------------------------------------------
// cigm_pkg
// Shared types, constants and helpers for the case-insensitive glob matcher.
// ----------------------------------------------------------------------------
package cigm_pkg;

    localparam int PATTERN_MAX = 32;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_ANY   = 8'h3F;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'd32;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_TEXT   = 2'd2,
        ACT_END    = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] byte_in;
    } in_item_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } out_item_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic       clear;
        logic       append;
        logic       restart;
        logic       step;
        logic [7:0] folded;
    } cell_ctrl_t;

    // handed from cell i to cell i+1
    typedef struct packed {
        logic carry;   // closed-active and star at position i
        logic adv;     // position i consumed the text byte
        logic filled;  // position i holds a pattern byte
    } cell_link_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

endpackage

@@ sv/cigm_if.sv @@
// ----------------------------------------------------------------------------
// cigm_item_if / cigm_result_if
// Valid/ready channels carrying input items and match results.
// ----------------------------------------------------------------------------
interface cigm_item_if import cigm_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cigm_result_if import cigm_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/case_insensitive_glob_match_core.sv @@
// ----------------------------------------------------------------------------
// case_insensitive_glob_match_core
// Whole-text wildcard matcher ('*' and '?'), ASCII case folded.
// ----------------------------------------------------------------------------
// Takes one item per clock. Each pattern position is a cell holding its
// folded byte and an active flag; a text byte updates all positions in the
// same cycle, with star closure rippling along the row of PATTERN_MAX cells,
// which sets the clock path. An end-of-text transfer puts its result in the
// output register on the next cycle; input is stalled only while that
// register is full and not being taken. Pattern bytes past PATTERN_MAX are
// dropped and flagged as overflow until the next clear.
module case_insensitive_glob_match_core import cigm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cigm_item_if.sink            item,
    cigm_result_if.source        result
);

    localparam int N = PATTERN_MAX;

    cell_ctrl_t       ctrl;
    cell_link_t       link [N+1];
    logic [N-1:0]     hit_vec;
    logic [N-1:0]     act_vec;
    logic [N-1:0]     filled_vec;
    logic             accept;

    logic             tail_act_reg;
    logic             tail_act_next;
    logic             tail_closed;
    logic             overflow_reg;
    logic             overflow_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    out_item_t        res_data_reg;
    out_item_t        res_data_next;

    assign item.ready = !res_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        ctrl.clear   = 1'b0;
        ctrl.append  = 1'b0;
        ctrl.restart = 1'b0;
        ctrl.step    = 1'b0;
        ctrl.folded  = fold_case(item.data.byte_in);
        if (accept)
        begin
            unique case (item.data.action)
                ACT_CLEAR:
                begin
                    ctrl.clear   = 1'b1;
                    ctrl.restart = 1'b1;
                end
                ACT_APPEND:
                begin
                    ctrl.append  = 1'b1;
                    ctrl.restart = 1'b1;
                end
                ACT_TEXT:
                begin
                    ctrl.step    = 1'b1;
                end
                ACT_END:
                begin
                    ctrl.restart = 1'b1;
                end
                default:
                begin
                    ctrl.restart = 1'b1;
                end
            endcase
        end
    end

    assign link[0].carry  = 1'b0;
    assign link[0].adv    = 1'b0;
    assign link[0].filled = 1'b1;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        cigm_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .first    (i == 0),
            .ctrl     (ctrl),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .hit      (hit_vec[i]),
            .active   (act_vec[i])
        );
        assign filled_vec[i] = link[i+1].filled;
    end

    assign tail_closed = tail_act_reg || link[N].carry;

    always_comb
    begin
        tail_act_next = tail_act_reg;
        if (ctrl.restart)
        begin
            tail_act_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            tail_act_next = link[N].adv;
        end

        overflow_next = overflow_reg;
        if (ctrl.clear)
        begin
            overflow_next = 1'b0;
        end
        else if (ctrl.append && link[N].filled)
        begin
            overflow_next = 1'b1;
        end

        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (accept && item.data.action == ACT_END)
        begin
            res_valid_next                 = 1'b1;
            res_data_next.matched          = (|hit_vec) || tail_closed;
            res_data_next.pattern_overflow = overflow_reg;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_act_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            tail_act_reg  <= tail_act_next;
            overflow_reg  <= overflow_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

`ifndef SYNTHESIS
    a_fill_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        ((filled_vec >> 1) & ~filled_vec) == '0)
        else $error("pattern fill is not contiguous");

    a_active_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (({act_vec[N-1:1], 1'b0} & ~{filled_vec[N-2:0], 1'b1}) == '0)
        && (!tail_act_reg || filled_vec[N-1]))
        else $error("active position beyond pattern length");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.data.action == ACT_CLEAR
        |=> filled_vec == '0 && !overflow_reg && act_vec[0])
        else $error("clear did not empty the pattern");

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.data.action == ACT_END |=> result.valid)
        else $error("end of text without result");

    a_restart_single: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.data.action != ACT_TEXT
        |=> $onehot({tail_act_reg, act_vec}) && act_vec[0])
        else $error("restart left extra active positions");
`endif

endmodule

@@ sv/cigm_cell.sv @@
// ----------------------------------------------------------------------------
// cigm_cell
// One pattern position: stored byte, fill flag and active flag.
// ----------------------------------------------------------------------------
module cigm_cell import cigm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       first,
    input  cell_ctrl_t ctrl,
    input  cell_link_t link_in,
    output cell_link_t link_out,
    output logic       hit,
    output logic       active
);

    logic [7:0] pat_reg;
    logic       filled_reg;
    logic       filled_next;
    logic       act_reg;
    logic       act_next;
    logic       load;
    logic       closed;
    logic       is_star;
    logic       is_match;

    assign load     = ctrl.append && link_in.filled && !filled_reg;
    assign closed   = act_reg || link_in.carry;
    assign is_star  = filled_reg && (pat_reg == CH_STAR);
    assign is_match = filled_reg && !is_star
                      && ((pat_reg == CH_ANY) || (pat_reg == ctrl.folded));

    assign link_out.carry  = closed && is_star;
    assign link_out.adv    = closed && is_match;
    assign link_out.filled = filled_reg;
    assign hit             = closed && !filled_reg;
    assign active          = act_reg;

    always_comb
    begin
        filled_next = filled_reg;
        if (ctrl.clear)
        begin
            filled_next = 1'b0;
        end
        else if (load)
        begin
            filled_next = 1'b1;
        end

        act_next = act_reg;
        if (ctrl.restart)
        begin
            act_next = first;
        end
        else if (ctrl.step)
        begin
            act_next = (closed && is_star) || link_in.adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            act_reg    <= first;
        end
        else
        begin
            filled_reg <= filled_next;
            act_reg    <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pat_reg <= ctrl.folded;
        end
    end

endmodule
